>>> src/crle_pkg.sv
// Shared types and constants for the cell run-length encoder.
// Used by the front classifier, the command queue, the byte sequencer and the top.
package crle_pkg;

  localparam int CELL_BYTES = 9;
  localparam int NUM_SLOTS = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int CFG_IDX_W = ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRESERVE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOLID = CFG_IDX_W'(1);

  localparam logic [7:0] RUN_MARK = 8'd255;
  localparam logic [7:0] SOLID_FULL_MARK = 8'd253;

  localparam int F_TYPE = 0;
  localparam int F_FLOOR = 1;
  localparam int F_CEIL = 2;
  localparam int F_WALL_TEX = 3;
  localparam int F_FLOOR_TEX = 4;
  localparam int F_CEIL_TEX = 5;
  localparam int F_VDELTA = 6;
  localparam int F_UPPER_TEX = 7;
  localparam int F_TAG = 8;

  localparam int SLOT_PRE_MARK = 0;
  localparam int SLOT_PRE_COUNT = 1;
  localparam int SLOT_REC = 2;
  localparam int SLOT_POST_MARK = SLOT_REC + CELL_BYTES;
  localparam int SLOT_POST_COUNT = SLOT_POST_MARK + 1;

  typedef logic [CELL_BYTES-1:0][7:0] crle_cell_t;

  typedef struct packed {
    logic       preserve_solids;
    logic [7:0] solid_code;
  } crle_cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [7:0]           count;
    crle_cell_t           rec;
  } crle_cmd_t;

  typedef struct packed {
    logic      valid;
    crle_cmd_t cmd;
  } crle_push_t;

  typedef struct packed {
    logic      valid;
    crle_cmd_t cmd;
  } crle_head_t;

endpackage

>>> src/crle_ifs.sv
// Stream interfaces for map cells in and coded bytes out.
// Depends on nothing; valid/ready handshake, a transfer when both are high.
interface crle_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_type;
  logic [7:0] floor_height;
  logic [7:0] ceil_height;
  logic [7:0] wall_tex;
  logic [7:0] floor_tex;
  logic [7:0] ceil_tex;
  logic [7:0] vertex_delta;
  logic [7:0] upper_tex;
  logic [7:0] cell_tag;
  logic       end_of_stream;

  modport source (
    output valid, cell_type, floor_height, ceil_height, wall_tex, floor_tex,
           ceil_tex, vertex_delta, upper_tex, cell_tag, end_of_stream,
    input  ready
  );
  modport sink (
    input  valid, cell_type, floor_height, ceil_height, wall_tex, floor_tex,
           ceil_tex, vertex_delta, upper_tex, cell_tag, end_of_stream,
    output ready
  );
endinterface

interface crle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;

  modport source (output valid, out_byte, last_of_item, input ready);
  modport sink (input valid, out_byte, last_of_item, output ready);
endinterface

>>> src/crle_front.sv
// Front classifier: accepts cells, compares them with the previous cell and keeps the run count.
// Depends on crle_pkg and crle_cell_if; emits one byte-slot command per cell that gives output.
module crle_front (
  input  logic                clk,
  input  logic                rst,
  crle_cell_if.sink           cells,
  input  crle_pkg::crle_cfg_t cfg,
  input  logic                queue_full,
  output crle_pkg::crle_push_t push
);

  crle_pkg::crle_cell_t cur;
  crle_pkg::crle_cell_t prev;
  logic                 have_previous;
  logic [7:0]           run_count;
  logic [7:0]           run_count_next;
  logic [7:0]           run_inc;
  logic                 accept;
  logic                 solid;
  logic                 short_rec;
  logic                 match_short;
  logic                 match_full;
  logic                 same;
  logic                 post_flush;
  logic                 pre_flush;
  crle_pkg::crle_cmd_t  cmd;

  assign cur[crle_pkg::F_TYPE]      = cells.cell_type;
  assign cur[crle_pkg::F_FLOOR]     = cells.floor_height;
  assign cur[crle_pkg::F_CEIL]      = cells.ceil_height;
  assign cur[crle_pkg::F_WALL_TEX]  = cells.wall_tex;
  assign cur[crle_pkg::F_FLOOR_TEX] = cells.floor_tex;
  assign cur[crle_pkg::F_CEIL_TEX]  = cells.ceil_tex;
  assign cur[crle_pkg::F_VDELTA]    = cells.vertex_delta;
  assign cur[crle_pkg::F_UPPER_TEX] = cells.upper_tex;
  assign cur[crle_pkg::F_TAG]       = cells.cell_tag;

  assign cells.ready = !queue_full;
  assign accept = cells.valid && cells.ready;

  always_comb begin
    solid = (cur[crle_pkg::F_TYPE] == cfg.solid_code);
    short_rec = solid && !cfg.preserve_solids;
    match_short = have_previous
                  && (cur[crle_pkg::F_TYPE] == prev[crle_pkg::F_TYPE])
                  && (cur[crle_pkg::F_WALL_TEX] == prev[crle_pkg::F_WALL_TEX])
                  && (cur[crle_pkg::F_VDELTA] == prev[crle_pkg::F_VDELTA]);
    match_full = match_short && (cur == prev);
    same = short_rec ? match_short : match_full;
    run_inc = run_count + 8'd1;
    pre_flush = !same && (run_count != 8'd0);
    post_flush = same && ((run_inc == crle_pkg::RUN_MARK) || cells.end_of_stream);

    cmd.mask = '0;
    cmd.mask[crle_pkg::SLOT_PRE_MARK] = pre_flush;
    cmd.mask[crle_pkg::SLOT_PRE_COUNT] = pre_flush;
    for (int i = 0; i < crle_pkg::CELL_BYTES; i++) begin
      if (short_rec) begin
        cmd.mask[crle_pkg::SLOT_REC + i] = !same && ((i == crle_pkg::F_TYPE)
                                          || (i == crle_pkg::F_WALL_TEX)
                                          || (i == crle_pkg::F_VDELTA));
      end else begin
        cmd.mask[crle_pkg::SLOT_REC + i] = !same;
      end
    end
    cmd.mask[crle_pkg::SLOT_POST_MARK] = post_flush;
    cmd.mask[crle_pkg::SLOT_POST_COUNT] = post_flush;
    cmd.count = same ? run_inc : run_count;
    cmd.rec = cur;
    if (solid && !short_rec) begin
      cmd.rec[crle_pkg::F_TYPE] = crle_pkg::SOLID_FULL_MARK;
    end

    if (!same || post_flush) begin
      run_count_next = 8'd0;
    end else begin
      run_count_next = run_inc;
    end

    push.valid = accept && (cmd.mask != '0);
    push.cmd = cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      run_count <= 8'd0;
      prev <= '0;
    end else if (accept) begin
      have_previous <= !cells.end_of_stream;
      run_count <= run_count_next;
      prev <= cur;
    end
  end

endmodule

>>> src/crle_queue.sv
// Short command queue between the front classifier and the byte sequencer.
// Depends on crle_pkg; depth is crle_pkg::QUEUE_DEPTH.
module crle_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  crle_pkg::crle_push_t push,
  output logic                 full,
  input  logic                 pop,
  output crle_pkg::crle_head_t head
);

  crle_pkg::crle_cmd_t              entries [crle_pkg::QUEUE_DEPTH];
  logic [crle_pkg::QPTR_W-1:0]      wr_ptr;
  logic [crle_pkg::QPTR_W-1:0]      rd_ptr;
  logic [crle_pkg::QCNT_W-1:0]      fill;
  logic                             do_push;
  logic                             do_pop;

  assign full = (fill == crle_pkg::QCNT_W'(crle_pkg::QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.cmd = entries[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == crle_pkg::QPTR_W'(crle_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + crle_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == crle_pkg::QPTR_W'(crle_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + crle_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + crle_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - crle_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> src/crle_back.sv
// Byte sequencer: walks each command's enabled byte slots, one byte per cycle unless stalled.
// Depends on crle_pkg and crle_byte_if; the output register decouples it from the consumer.
module crle_back (
  input  logic                 clk,
  input  logic                 rst,
  input  crle_pkg::crle_head_t head,
  output logic                 pop,
  crle_byte_if.source          codes
);

  logic [crle_pkg::NUM_SLOTS-1:0] cur_mask;
  logic [crle_pkg::NUM_SLOTS-1:0] cur_mask_next;
  logic [crle_pkg::NUM_SLOTS-1:0] pick;
  logic [crle_pkg::NUM_SLOTS-1:0] rest;
  logic [7:0]                     cur_count;
  crle_pkg::crle_cell_t           cur_rec;
  logic [crle_pkg::NUM_SLOTS-1:0][7:0] slot_bytes;
  logic [7:0]                     sel_byte;
  logic                           emit;
  logic                           out_valid;
  logic [7:0]                     out_byte;
  logic                           out_last;

  always_comb begin
    slot_bytes[crle_pkg::SLOT_PRE_MARK] = crle_pkg::RUN_MARK;
    slot_bytes[crle_pkg::SLOT_PRE_COUNT] = cur_count;
    for (int i = 0; i < crle_pkg::CELL_BYTES; i++) begin
      slot_bytes[crle_pkg::SLOT_REC + i] = cur_rec[i];
    end
    slot_bytes[crle_pkg::SLOT_POST_MARK] = crle_pkg::RUN_MARK;
    slot_bytes[crle_pkg::SLOT_POST_COUNT] = cur_count;

    pick = cur_mask & (~cur_mask + crle_pkg::NUM_SLOTS'(1));
    rest = cur_mask & ~pick;
    sel_byte = 8'd0;
    for (int s = 0; s < crle_pkg::NUM_SLOTS; s++) begin
      if (pick[s]) begin
        sel_byte = sel_byte | slot_bytes[s];
      end
    end

    emit = (cur_mask != '0) && (!out_valid || codes.ready);
    pop = head.valid && ((cur_mask == '0) || (emit && (rest == '0)));

    if (pop) begin
      cur_mask_next = head.cmd.mask;
    end else if (emit) begin
      cur_mask_next = rest;
    end else begin
      cur_mask_next = cur_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_count <= head.cmd.count;
      cur_rec <= head.cmd.rec;
    end
    if (emit) begin
      out_byte <= sel_byte;
      out_last <= (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      cur_mask <= cur_mask_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (codes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign codes.valid = out_valid;
  assign codes.out_byte = out_byte;
  assign codes.last_of_item = out_last;

endmodule

>>> src/cell_run_length_encoder.sv
// Top level of the cell run-length encoder with its configuration registers.
// Depends on crle_pkg, crle_ifs, crle_front, crle_queue and crle_back.
//
//   Port     Role          Contents
//   cells    stream in     one map cell per transfer, end_of_stream marks the last cell
//   codes    stream out    one coded byte per transfer, last_of_item on a cell's final byte
//   apb      configuration preserve_solids at 0x0, solid_code at 0x4
//
// A cell is taken while the command queue has room and yields 0 to 11 bytes. The output
// delivers one byte per cycle while the consumer is ready; cells that only extend a run
// give no bytes. The first byte passes the queue, the sequencer's command registers and
// the output register. Reset is synchronous and clears the run history and the queue.
// Each side stalls on its own through the queue and the output register.
module cell_run_length_encoder (
  input  logic                          clk,
  input  logic                          rst,
  crle_cell_if.sink                     cells,
  crle_byte_if.source                   codes,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crle_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  crle_pkg::crle_cfg_t             cfg;
  crle_pkg::crle_push_t            push;
  crle_pkg::crle_head_t            head;
  logic                            queue_full;
  logic                            pop;
  logic [crle_pkg::CFG_IDX_W-1:0]  reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[crle_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preserve_solids <= 1'b0;
      cfg.solid_code <= 8'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        crle_pkg::REG_PRESERVE: cfg.preserve_solids <= pwdata[0];
        crle_pkg::REG_SOLID:    cfg.solid_code <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      crle_pkg::REG_PRESERVE: prdata = {31'd0, cfg.preserve_solids};
      crle_pkg::REG_SOLID:    prdata = {24'd0, cfg.solid_code};
      default:                prdata = 32'd0;
    endcase
  end

  crle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cells      (cells),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push)
  );

  crle_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  crle_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .codes (codes)
  );

endmodule
